// ===== src/nrmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants for the RMC sentence parser
// Byte classes, queue entry, record layout, header text and scale table.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam int FIELD_CHARS = 10;  // bytes of a field that feed its value
  localparam int FRAC_DIGITS = 4;   // kept fraction digits, value scaled by 10^4
  localparam int HDR_LEN     = 6;   // length of "$GPRMC"

  localparam int ACC_W   = 40;
  localparam int DATE_W  = 32;
  localparam int SCALE_W = 20;      // holds 10^6, the largest scale
  localparam int FRAC_W  = 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [ACC_W-1:0]  MAX_ACC  = {ACC_W{1'b1}};
  localparam logic [DATE_W-1:0] MAX_DATE = {DATE_W{1'b1}};

  // field indexes within a sentence
  localparam logic [3:0] FLD_HDR    = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_COMMA,
    CLS_DIGIT,
    CLS_POINT,
    CLS_OTHER
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  ch;
    byte_class_e cls;
  } q_entry_t;

  typedef struct packed {
    logic [ACC_W-1:0]  utc_time;
    logic [7:0]        fix_status;
    logic [ACC_W-1:0]  latitude;
    logic [7:0]        lat_hemisphere;
    logic [ACC_W-1:0]  longitude;
    logic [7:0]        lon_hemisphere;
    logic [ACC_W-1:0]  ground_speed;
    logic [ACC_W-1:0]  ground_course;
    logic [DATE_W-1:0] fix_date;
  } rec_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h4D;  // M
      3'd5:    c = 8'h43;  // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [SCALE_W-1:0] p;
    case (k)
      3'd0:    p = SCALE_W'(1);
      3'd1:    p = SCALE_W'(10);
      3'd2:    p = SCALE_W'(100);
      3'd3:    p = SCALE_W'(1000);
      3'd4:    p = SCALE_W'(10000);
      3'd5:    p = SCALE_W'(100000);
      3'd6:    p = SCALE_W'(1000000);
      default: p = SCALE_W'(1);
    endcase
    return p;
  endfunction

endpackage

// ===== src/nrmc_front.sv =====
// ----------------------------------------------------------------------------
// nrmc_front: byte intake and classification
// Takes sentence bytes from the input channel, tags each with its class and
// pushes it into the byte queue.
// ----------------------------------------------------------------------------
module nrmc_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_char_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output nrmc_pkg::q_entry_t push_entry_o
);
  import nrmc_pkg::*;

  byte_class_e cls;

  always_comb begin
    if (rx_char_i == CHAR_NUL) begin
      cls = CLS_END;
    end else if (rx_char_i == CHAR_COMMA) begin
      cls = CLS_COMMA;
    end else if (rx_char_i >= CHAR_ZERO && rx_char_i <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else if (rx_char_i == CHAR_POINT) begin
      cls = CLS_POINT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign push_valid_o     = in_valid_i;
  assign in_ready_o       = push_ready_i;
  assign push_entry_o.ch  = rx_char_i;
  assign push_entry_o.cls = cls;

endmodule

// ===== src/nrmc_queue.sv =====
// ----------------------------------------------------------------------------
// nrmc_queue: short byte queue
// Decouples intake from the parser so each side can stall on its own.
// ----------------------------------------------------------------------------
module nrmc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  nrmc_pkg::q_entry_t push_entry_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output nrmc_pkg::q_entry_t pop_entry_o
);
  import nrmc_pkg::*;

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== src/nrmc_back.sv =====
// ----------------------------------------------------------------------------
// nrmc_back: field parser, held record and result register
// Pops one classified word per cycle unless a terminator waits on the result
// register, runs the per-field number parser and header check, updates the
// record at each field end and loads the result register at the terminator.
// ----------------------------------------------------------------------------
module nrmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  nrmc_pkg::q_entry_t pop_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output nrmc_pkg::rec_t     rec_o
);
  import nrmc_pkg::*;

  logic [3:0]        field_q, field_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [3:0]        cpos_q, cpos_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              point_q, point_d;
  logic              stop_q, stop_d;
  logic [7:0]        first_q, first_d;
  rec_t              rec_q, rec_d;
  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  rec_t              out_rec_q;

  logic                     fire, is_end;
  logic [7:0]               c;
  logic [ACC_W+3:0]         mul10;
  logic [ACC_W-1:0]         acc_digit;
  logic [ACC_W+SCALE_W-1:0] prod;
  logic [ACC_W-1:0]         scaled;
  logic [DATE_W-1:0]        date_val;
  logic                     hdr_after_end;
  rec_t                     rec_end;

  assign c      = pop_entry_i.ch;
  assign is_end = (pop_entry_i.cls == CLS_END);
  // a terminator waits until the result register is free
  assign pop_ready_o = !is_end || !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;

  // accumulate one digit: acc*10 + d, saturating
  assign mul10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (ACC_W+4)'(c[3:0]);
  assign acc_digit = (mul10[ACC_W+3:ACC_W] != '0) ? MAX_ACC : mul10[ACC_W-1:0];

  // pad missing fraction digits: acc * 10^(FRAC_DIGITS - frac), saturating
  assign prod = {{SCALE_W{1'b0}}, acc_q}
              * {{ACC_W{1'b0}}, pow10(FRAC_W'(FRAC_DIGITS) - frac_q)};
  assign scaled = (prod[ACC_W+SCALE_W-1:ACC_W] != '0) ? MAX_ACC : prod[ACC_W-1:0];

  assign date_val = (acc_q[ACC_W-1:DATE_W] != '0) ? MAX_DATE : acc_q[DATE_W-1:0];

  assign hdr_after_end = hdr_ok_q && !(field_q == FLD_HDR && cpos_q != 4'(HDR_LEN));

  always_comb begin
    rec_end = rec_q;
    if (field_q != FLD_HDR && hdr_ok_q) begin
      case (field_q)
        FLD_TIME:   rec_end.utc_time       = scaled;
        FLD_STATUS: rec_end.fix_status     = first_q;
        FLD_LAT:    rec_end.latitude       = scaled;
        FLD_NS:     rec_end.lat_hemisphere = first_q;
        FLD_LON:    rec_end.longitude      = scaled;
        FLD_EW:     rec_end.lon_hemisphere = first_q;
        FLD_SPEED:  rec_end.ground_speed   = scaled;
        FLD_COURSE: rec_end.ground_course  = scaled;
        FLD_DATE:   rec_end.fix_date       = date_val;
        default:    rec_end = rec_q;
      endcase
    end
  end

  always_comb begin
    field_d     = field_q;
    hdr_ok_d    = hdr_ok_q;
    cpos_d      = cpos_q;
    acc_d       = acc_q;
    frac_d      = frac_q;
    point_d     = point_q;
    stop_d      = stop_q;
    first_d     = first_q;
    rec_d       = rec_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (fire) begin
      case (pop_entry_i.cls)
        CLS_END, CLS_COMMA: begin
          rec_d   = rec_end;
          cpos_d  = '0;
          acc_d   = '0;
          frac_d  = '0;
          point_d = 1'b0;
          stop_d  = 1'b0;
          first_d = '0;
          if (is_end) begin
            field_d     = FLD_HDR;
            hdr_ok_d    = 1'b1;
            out_valid_d = 1'b1;
          end else begin
            hdr_ok_d = hdr_after_end;
            if (field_q != FLD_LAST) begin
              field_d = field_q + 1'b1;
            end
          end
        end
        default: begin
          if (field_q == FLD_HDR && cpos_q < 4'(HDR_LEN) && c != hdr_char(cpos_q[2:0])) begin
            hdr_ok_d = 1'b0;
          end
          if (cpos_q < 4'(FIELD_CHARS)) begin
            if (cpos_q == '0) begin
              first_d = c;
            end
            if (!stop_q) begin
              if (pop_entry_i.cls == CLS_DIGIT) begin
                if (!point_q) begin
                  acc_d = acc_digit;
                end else if (frac_q < FRAC_W'(FRAC_DIGITS)) begin
                  acc_d  = acc_digit;
                  frac_d = frac_q + 1'b1;
                end
              end else if (pop_entry_i.cls == CLS_POINT && !point_q && field_q != FLD_DATE) begin
                point_d = 1'b1;
              end else begin
                stop_d = 1'b1;
              end
            end
          end
          if (cpos_q != 4'hF) begin
            cpos_d = cpos_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= FLD_HDR;
      hdr_ok_q    <= 1'b1;
      cpos_q      <= '0;
      acc_q       <= '0;
      frac_q      <= '0;
      point_q     <= 1'b0;
      stop_q      <= 1'b0;
      first_q     <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      field_q     <= field_d;
      hdr_ok_q    <= hdr_ok_d;
      cpos_q      <= cpos_d;
      acc_q       <= acc_d;
      frac_q      <= frac_d;
      point_q     <= point_d;
      stop_q      <= stop_d;
      first_q     <= first_d;
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_end) begin
      ok_q      <= hdr_after_end;
      out_rec_q <= rec_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign rec_o       = out_rec_q;

endmodule

// ===== src/nmea_rmc_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser: RMC sentence to position record
// Splits a byte stream into comma fields and emits one record per sentence.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, rx_char_i) carries one sentence byte
// per word; a NUL byte ends the sentence. Each NUL produces exactly one word
// on the output channel (out_valid_o/out_ready_i) with ok_o and the held
// record: time, status, position, speed, course (value times 10^4) and date.
// Fields missing from a sentence keep their earlier values; a bad header
// gives ok_o low and leaves the record untouched.
// Throughput: one byte per cycle while out_ready_i keeps up. The result
// register is loaded as the terminator is popped from the queue. The
// per-byte update (44-bit times-ten add, 40x20 scale multiply) sets the rate.
// A four-word byte queue sits between intake and parser; when the receiver
// stalls, the result holds, the parser stops at the next terminator and
// in_ready_o drops once the queue is full.
// Reset empties the queue, clears the record to zero and restarts the
// sentence at field 0.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [39:0] utc_time_o,
  output logic [7:0]  fix_status_o,
  output logic [39:0] latitude_o,
  output logic [7:0]  lat_hemisphere_o,
  output logic [39:0] longitude_o,
  output logic [7:0]  lon_hemisphere_o,
  output logic [39:0] ground_speed_o,
  output logic [39:0] ground_course_o,
  output logic [31:0] fix_date_o
);
  import nrmc_pkg::*;

  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop_ready;
  q_entry_t pop_entry;
  rec_t     rec;

  nrmc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_char_i    (rx_char_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  nrmc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  nrmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .rec_o       (rec)
  );

  assign utc_time_o       = rec.utc_time;
  assign fix_status_o     = rec.fix_status;
  assign latitude_o       = rec.latitude;
  assign lat_hemisphere_o = rec.lat_hemisphere;
  assign longitude_o      = rec.longitude;
  assign lon_hemisphere_o = rec.lon_hemisphere;
  assign ground_speed_o   = rec.ground_speed;
  assign ground_course_o  = rec.ground_course;
  assign fix_date_o       = rec.fix_date;

  // a terminator leaves the queue only when the result register can take it
  a_end_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && pop_entry.cls == CLS_END) |-> (!out_valid_o || out_ready_i))
    else $error("terminator popped while result register busy");

  // an accepted byte is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pop_valid)
    else $error("accepted byte missing from queue");

  // a new result appears only right after a terminator was popped
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop_valid && pop_ready && pop_entry.cls == CLS_END))
    else $error("result without terminator");

endmodule
